>>> sv/wsfd_pkg.sv
// ============================================================================
// wsfd_pkg: shared types and constants of the WebSocket frame deframer
// Holds the parse phase encoding, the result record and the header codes.
// ============================================================================
package wsfd_pkg;

    // Parse phase of the frame header and payload walk
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // One result item as it travels from the parser to the output register
    typedef struct packed {
        logic [3:0] frame_opcode;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       fragment_error;
    } result_t;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Number of bytes in the extended length fields and in the mask key
    localparam logic [3:0] LEN_BYTES_16  = 4'd2;
    localparam logic [3:0] LEN_BYTES_64  = 4'd8;
    localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

endpackage

>>> sv/websocket_frame_deframer_unit.sv
// ============================================================================
// websocket_frame_deframer_unit: WebSocket receive-side frame deframer
// Splits a received byte stream into frames and delivers unmasked payload.
// ============================================================================
// Usage:
// The input channel (in_valid, in_ready, rx_byte) takes one raw link byte
// per transaction. The output channel (out_valid, out_ready and the result
// fields) gives one result per payload byte, tagged with the frame opcode;
// the last one of a frame carries frame_end, and fragment_error when the
// FIN bit was clear. A zero-length frame gives a single result with
// byte_valid low. Header, extended length and mask key bytes give no result.
// Each byte is held in an input register, parsed by the header and unmask
// logic, and the result lands in an output register, where out_valid rises
// once it is loaded. While the receiver keeps up a new byte is taken every
// cycle, so throughput is one byte per cycle, set by the single parser pass.
// When the receiver stalls, the result waits in the output register and
// the next byte waits in the input register; in_ready drops only when both
// are full. Reset empties both registers and puts the parser at the first
// header byte of a new frame.
// ============================================================================
module websocket_frame_deframer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  frame_opcode,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        frame_end,
    output logic        fragment_error
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        rx_byte_reg;
    logic              out_free;
    logic              step;
    logic              res_valid;
    wsfd_pkg::result_t res;
    wsfd_pkg::result_t out_data;

    // A held byte is processed whenever its result has somewhere to go
    assign step     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input byte capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rx_byte_reg <= rx_byte;
        end
    end

    wsfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (rx_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .load_data (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Result fields onto the ports
    assign frame_opcode   = out_data.frame_opcode;
    assign payload_byte   = out_data.payload_byte;
    assign byte_valid     = out_data.byte_valid;
    assign frame_end      = out_data.frame_end;
    assign fragment_error = out_data.fragment_error;

endmodule

>>> sv/wsfd_parser.sv
// ============================================================================
// wsfd_parser: frame header parser and payload unmasker
// Holds the parse state and turns one received byte per step into at most
// one result record.
// ============================================================================
module wsfd_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    output wsfd_pkg::result_t  res
);

    wsfd_pkg::phase_t phase_reg, phase_next;
    logic             fin_reg, fin_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             mask_present_reg, mask_present_next;
    logic [3:0]       len_left_reg, len_left_next;
    logic [63:0]      remaining_reg, remaining_next;
    logic [31:0]      key_reg, key_next;
    logic [2:0]       key_left_reg, key_left_next;
    logic [1:0]       position_reg, position_next;

    logic [6:0]       len7;
    logic             len_is_ext;
    logic [63:0]      rem_shift;
    logic [63:0]      rem_dec;
    logic [3:0]       len_left_dec;
    logic [2:0]       key_left_dec;
    logic [7:0]       key_byte;
    logic [7:0]       key_sel;

    // Shared datapath terms
    assign len7         = rx_byte[6:0];
    assign len_is_ext   = (len7 == wsfd_pkg::LEN_CODE_16) || (len7 == wsfd_pkg::LEN_CODE_64);
    assign rem_shift    = {remaining_reg[55:0], rx_byte};
    assign rem_dec      = remaining_reg - 64'd1;
    assign len_left_dec = len_left_reg - 4'd1;
    assign key_left_dec = key_left_reg - 3'd1;

    // Key byte for the current payload position, first key byte first
    always_comb
    begin
        case (position_reg)
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
        key_byte = mask_present_reg ? key_sel : 8'd0;
    end

    // Next state of the parser
    always_comb
    begin
        phase_next        = phase_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        mask_present_next = mask_present_reg;
        len_left_next     = len_left_reg;
        remaining_next    = remaining_reg;
        key_next          = key_reg;
        key_left_next     = key_left_reg;
        position_next     = position_reg;

        case (phase_reg)
            wsfd_pkg::PH_HDR1:
            begin
                mask_present_next = rx_byte[7];
                if (len_is_ext)
                begin
                    len_left_next  = (len7 == wsfd_pkg::LEN_CODE_16) ?
                                     wsfd_pkg::LEN_BYTES_16 : wsfd_pkg::LEN_BYTES_64;
                    remaining_next = 64'd0;
                    phase_next     = wsfd_pkg::PH_EXTLEN;
                end
                else
                begin
                    remaining_next = {57'd0, len7};
                    if (rx_byte[7])
                    begin
                        key_left_next = wsfd_pkg::MASK_KEY_BYTES;
                        phase_next    = wsfd_pkg::PH_MASK;
                    end
                    else
                    begin
                        key_next      = 32'd0;
                        position_next = 2'd0;
                        phase_next    = (len7 == 7'd0) ? wsfd_pkg::PH_HDR0
                                                       : wsfd_pkg::PH_PAYLOAD;
                    end
                end
            end

            wsfd_pkg::PH_EXTLEN:
            begin
                remaining_next = rem_shift;
                len_left_next  = len_left_dec;
                if (len_left_dec == 4'd0)
                begin
                    if (mask_present_reg)
                    begin
                        key_left_next = wsfd_pkg::MASK_KEY_BYTES;
                        phase_next    = wsfd_pkg::PH_MASK;
                    end
                    else
                    begin
                        key_next      = 32'd0;
                        position_next = 2'd0;
                        phase_next    = (rem_shift == 64'd0) ? wsfd_pkg::PH_HDR0
                                                             : wsfd_pkg::PH_PAYLOAD;
                    end
                end
            end

            wsfd_pkg::PH_MASK:
            begin
                key_next      = {key_reg[23:0], rx_byte};
                key_left_next = key_left_dec;
                if (key_left_dec == 3'd0)
                begin
                    position_next = 2'd0;
                    phase_next    = (remaining_reg == 64'd0) ? wsfd_pkg::PH_HDR0
                                                             : wsfd_pkg::PH_PAYLOAD;
                end
            end

            wsfd_pkg::PH_PAYLOAD:
            begin
                remaining_next = rem_dec;
                position_next  = position_reg + 2'd1;
                if (rem_dec == 64'd0)
                begin
                    phase_next = wsfd_pkg::PH_HDR0;
                end
            end

            default:
            begin
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                phase_next  = wsfd_pkg::PH_HDR1;
            end
        endcase
    end

    // Result produced by the current byte
    always_comb
    begin
        res_valid          = 1'b0;
        res.frame_opcode   = opcode_reg;
        res.payload_byte   = 8'd0;
        res.byte_valid     = 1'b0;
        res.frame_end      = 1'b1;
        res.fragment_error = ~fin_reg;

        case (phase_reg)
            wsfd_pkg::PH_HDR1:
            begin
                res_valid = !len_is_ext && !rx_byte[7] && (len7 == 7'd0);
            end

            wsfd_pkg::PH_EXTLEN:
            begin
                res_valid = (len_left_dec == 4'd0) && !mask_present_reg &&
                            (rem_shift == 64'd0);
            end

            wsfd_pkg::PH_MASK:
            begin
                res_valid = (key_left_dec == 3'd0) && (remaining_reg == 64'd0);
            end

            wsfd_pkg::PH_PAYLOAD:
            begin
                res_valid          = 1'b1;
                res.payload_byte   = rx_byte ^ key_byte;
                res.byte_valid     = 1'b1;
                res.frame_end      = (rem_dec == 64'd0);
                res.fragment_error = (rem_dec == 64'd0) && !fin_reg;
            end

            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Parser state registers, advanced once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= wsfd_pkg::PH_HDR0;
            fin_reg          <= 1'b0;
            opcode_reg       <= 4'd0;
            mask_present_reg <= 1'b0;
            len_left_reg     <= 4'd0;
            remaining_reg    <= 64'd0;
            key_reg          <= 32'd0;
            key_left_reg     <= 3'd0;
            position_reg     <= 2'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            mask_present_reg <= mask_present_next;
            len_left_reg     <= len_left_next;
            remaining_reg    <= remaining_next;
            key_reg          <= key_next;
            key_left_reg     <= key_left_next;
            position_reg     <= position_next;
        end
    end

    // Every payload byte yields a result
    a_payload_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == wsfd_pkg::PH_PAYLOAD) |-> res_valid)
        else $error("payload byte produced no result");

    // An empty-frame marker always closes its frame
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.byte_valid) |-> res.frame_end)
        else $error("empty-frame marker without frame end");

    // After the last result of a frame the parser waits for a new header
    a_end_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.frame_end) |=> (phase_reg == wsfd_pkg::PH_HDR0))
        else $error("parser did not return to header phase after frame end");

    // State only moves when a byte is processed
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(remaining_reg)))
        else $error("parser state changed without a byte");

endmodule

>>> sv/wsfd_out_reg.sv
// ============================================================================
// wsfd_out_reg: result register of the deframer
// Holds one result record and presents it on a valid/ready channel.
// ============================================================================
module wsfd_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  wsfd_pkg::result_t  load_data,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_ready,
    output wsfd_pkg::result_t  out_data
);

    logic              valid_reg, valid_next;
    wsfd_pkg::result_t data_reg;

    // The register can take a new result when empty or being drained
    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Control flag of the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload, loaded without reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> bench/tb_websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_websocket_frame_deframer_unit: self-checking bench for the deframer
// Drives whole frames byte by byte into the input channel. A predictor
// follows the header, length, key and payload walk of each accepted byte.
// A checker compares every output transaction with the oldest expected
// result. Directed frames come first, then random frames with random idling,
// a long receiver hold-off, sender pauses and a frame with a huge length.
// ============================================================================
module tb_websocket_frame_deframer_unit;

    // Frame opcodes used by the directed frames
    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BIN    = 4'h2;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_RSVD_F = 4'hF;

    // Cycles to let in-flight bytes settle after the last expected result
    localparam int DRAIN_CYCLES = 6;

    // Encoding of the length field in a frame header
    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] frame_opcode;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       fragment_error;

    // Predictor state, mirroring the parser of the block
    wsfd_pkg::phase_t phase = wsfd_pkg::PH_HDR0;
    logic        fin = 1'b0;
    logic [3:0]  opcode = 4'h0;
    logic        mask_on = 1'b0;
    logic [3:0]  len_left = 4'h0;
    logic [63:0] remaining = 64'h0;
    logic [31:0] key = 32'h0;
    logic [2:0]  key_left = 3'h0;
    logic [1:0]  key_pos = 2'h0;

    wsfd_pkg::result_t expected_q[$];
    int      mismatches = 0;
    int      bytes_sent = 0;
    bit      idle_on = 1'b1;
    int      holdoff_left = 0;

    websocket_frame_deframer_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_opcode   (frame_opcode),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .frame_end      (frame_end),
        .fragment_error (fragment_error)
    );

    // Clock generation
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog in case the block hangs
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Queues the result the block should give for the current frame.
    task automatic queue_result(input logic [7:0] data, input logic valid, input logic last);
        wsfd_pkg::result_t r;
        r.frame_opcode   = opcode;
        r.payload_byte   = data;
        r.byte_valid     = valid;
        r.frame_end      = last;
        r.fragment_error = last && !fin;
        expected_q.insert(expected_q.size(), r);
    endtask

    // Header complete up to the key: either the payload follows or the frame is empty.
    task automatic start_payload();
        key_pos = 2'h0;
        if (remaining == 64'h0)
        begin
            queue_result(8'h00, 1'b0, 1'b1);
            phase = wsfd_pkg::PH_HDR0;
        end
        else
        begin
            phase = wsfd_pkg::PH_PAYLOAD;
        end
    endtask

    // Length known: read the key when the frame is masked.
    task automatic length_known();
        if (mask_on)
        begin
            key_left = wsfd_pkg::MASK_KEY_BYTES;
            phase = wsfd_pkg::PH_MASK;
        end
        else
        begin
            key = 32'h0;
            start_payload();
        end
    endtask

    // Advances the frame walk by one accepted byte.
    task automatic predict_byte(input logic [7:0] b);
        logic [6:0] len7;
        logic [7:0] k;
        case (phase)
            wsfd_pkg::PH_HDR1:
            begin
                mask_on = b[7];
                len7 = b[6:0];
                if (len7 == wsfd_pkg::LEN_CODE_16 || len7 == wsfd_pkg::LEN_CODE_64)
                begin
                    len_left = (len7 == wsfd_pkg::LEN_CODE_16) ?
                               wsfd_pkg::LEN_BYTES_16 : wsfd_pkg::LEN_BYTES_64;
                    remaining = 64'h0;
                    phase = wsfd_pkg::PH_EXTLEN;
                end
                else
                begin
                    remaining = {57'h0, len7};
                    length_known();
                end
            end
            wsfd_pkg::PH_EXTLEN:
            begin
                remaining = {remaining[55:0], b};
                len_left = len_left - 4'h1;
                if (len_left == 4'h0)
                    length_known();
            end
            wsfd_pkg::PH_MASK:
            begin
                key = {key[23:0], b};
                key_left = key_left - 3'h1;
                if (key_left == 3'h0)
                    start_payload();
            end
            wsfd_pkg::PH_PAYLOAD:
            begin
                k = mask_on ? key[8 * (3 - int'(key_pos)) +: 8] : 8'h00;
                remaining = remaining - 64'h1;
                key_pos = key_pos + 2'h1;
                queue_result(b ^ k, 1'b1, remaining == 64'h0);
                if (remaining == 64'h0)
                    phase = wsfd_pkg::PH_HDR0;
            end
            default:
            begin
                fin = b[7];
                opcode = b[3:0];
                phase = wsfd_pkg::PH_HDR1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one byte, idling at random beforehand, and waits for the transaction.
    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    // Sends a frame header followed by npay random payload bytes.
    task automatic send_frame(input logic fin_bit, input logic [2:0] rsv,
                              input logic [3:0] op, input logic masked,
                              input len_form_t form, input logic [63:0] len,
                              input logic [31:0] mkey, input int npay);
        logic [6:0] len7;
        send_byte({fin_bit, rsv, op});
        case (form)
            LEN_EXT16: len7 = wsfd_pkg::LEN_CODE_16;
            LEN_EXT64: len7 = wsfd_pkg::LEN_CODE_64;
            default:   len7 = len[6:0];
        endcase
        send_byte({masked, len7});
        if (form == LEN_EXT16)
        begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else if (form == LEN_EXT64)
        begin
            for (int i = 7; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        end
        if (masked)
        begin
            for (int i = 3; i >= 0; i--)
                send_byte(mkey[8 * i +: 8]);
        end
        for (int i = 0; i < npay; i++)
            send_byte(8'($urandom));
    endtask

    // Stops offering bytes until every expected result has been taken.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Builds one well-formed frame with random header fields and content.
    task automatic send_random_frame();
        int        pick;
        len_form_t form;
        int        len;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            form = LEN_SHORT;
            len = $urandom_range(0, 20);
        end
        else if (pick < 75)
        begin
            form = LEN_SHORT;
            len = $urandom_range(21, 125);
        end
        else if (pick < 88)
        begin
            form = LEN_EXT16;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 40);
        end
        else
        begin
            form = LEN_EXT64;
            len = $urandom_range(0, 24);
        end
        send_frame($urandom_range(0, 99) < 80, 3'($urandom), 4'($urandom),
                   1'($urandom), form, 64'(len), $urandom, len);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side and checker
    // ------------------------------------------------------------------------

    // Reports one field that differs from its expected value.
    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Checks each output transaction and drives out_ready, with idling and hold-offs.
    always @(posedge clk)
    begin
        wsfd_pkg::result_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %0h/%0h",
                             $time, frame_opcode, payload_byte);
                    mismatches++;
                end
                else
                begin
                    e = expected_q[0];
                    expected_q.delete(0);
                    check_field("frame_opcode", 8'(e.frame_opcode), 8'(frame_opcode));
                    check_field("payload_byte", e.payload_byte, payload_byte);
                    check_field("byte_valid", 8'(e.byte_valid), 8'(byte_valid));
                    check_field("frame_end", 8'(e.frame_end), 8'(frame_end));
                    check_field("fragment_error", 8'(e.fragment_error), 8'(fragment_error));
                end
            end
            if (holdoff_left > 0)
            begin
                out_ready <= 1'b0;
                holdoff_left--;
            end
            else if (idle_on)
            begin
                out_ready <= ($urandom_range(0, 99) >= 29);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero-length frames give a single empty marker, masked or not.
    task automatic test_empty_frames();
        send_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
        send_frame(1'b0, 3'b111, OPC_CONT, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
    endtask

    // Short frames: plain, masked with key wrap, reserved bits set, FIN clear.
    task automatic test_short_frames();
        send_frame(1'b1, 3'b000, OPC_BIN, 1'b0, LEN_SHORT, 64'd3, 32'h0, 3);
        send_frame(1'b0, 3'b101, OPC_RSVD_F, 1'b1, LEN_SHORT, 64'd5, 32'hA5C3_0FF0, 5);
        send_frame(1'b1, 3'b010, OPC_PING, 1'b1, LEN_SHORT, 64'd1, 32'h0, 1);
        send_frame(1'b1, 3'b000, OPC_TEXT, 1'b1, LEN_SHORT, 64'd125, 32'h0102_8040, 125);
    endtask

    // Extended lengths, including non-minimal forms and zero in both widths.
    task automatic test_extended_lengths();
        send_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, LEN_EXT16, 64'd0, 32'h0, 0);
        send_frame(1'b1, 3'b000, OPC_BIN, 1'b0, LEN_EXT16, 64'd126, 32'h0, 126);
        send_frame(1'b0, 3'b000, OPC_BIN, 1'b1, LEN_EXT16, 64'd257, 32'h5A5A_A5A5, 257);
        send_frame(1'b1, 3'b000, OPC_PING, 1'b1, LEN_EXT64, 64'd0, 32'h1234_5678, 0);
        send_frame(1'b0, 3'b011, OPC_CONT, 1'b0, LEN_EXT64, 64'd7, 32'h0, 7);
    endtask

    // Random frames until the byte budget is used up.
    task automatic test_random_traffic(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
            send_random_frame();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_no_idle_stretch();
        idle_on = 1'b0;
        test_random_traffic(200);
        idle_on = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills up.
    task automatic test_receiver_holdoff();
        wait_for_drain();
        idle_on = 1'b0;
        holdoff_left = 80;
        send_frame(1'b1, 3'b000, OPC_BIN, 1'b1, LEN_SHORT, 64'd60, $urandom, 60);
        idle_on = 1'b1;
    endtask

    // The sender pauses until all results are out, then resumes.
    task automatic test_sender_pause();
        for (int i = 0; i < 3; i++)
        begin
            send_random_frame();
            wait_for_drain();
        end
    endtask

    // A 64-bit length with its top bit set; the frame never ends within the run.
    task automatic test_huge_length();
        send_frame(1'b1, 3'b000, OPC_BIN, 1'b1, LEN_EXT64, 64'hFFA5_5A00_C33C_0081,
                   $urandom, 40);
    endtask

    // Test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_frames();
        test_short_frames();
        test_extended_lengths();
        wait_for_drain();
        test_random_traffic(100);
        test_no_idle_stretch();
        test_receiver_holdoff();
        test_sender_pause();
        test_random_traffic(150);
        test_huge_length();
        wait_for_drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
sv/wsfd_pkg.sv
sv/wsfd_parser.sv
sv/wsfd_out_reg.sv
sv/websocket_frame_deframer_unit.sv
bench/tb_websocket_frame_deframer_unit.sv
